// File: design/pud_pkg.sv
// shared types, constants and the hex digit decode for the percent url decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package pud_pkg;

    localparam logic [7:0]  PCT_CHAR      = 8'h25;
    localparam logic [7:0]  PLUS_CHAR     = 8'h2B;
    localparam logic [7:0]  SPACE_CHAR    = 8'h20;
    localparam logic [15:0] MAX_OUT_RESET = 16'd1023;
    localparam int          QUEUE_DEPTH   = 4;
    localparam int          MAX_RESULTS   = 3;

    // one classified input transaction: the decoded bytes it emits
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        logic            last;
        logic [15:0]     base;
    } t_op;

    // queue status seen by the result sequencer and the top level
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // hex digit decode: bit 4 set when the byte is a valid digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/pud_front.sv
// front end: escape tracking, candidate bytes, output limit, op build
// depends on pud_pkg
`timescale 1ns / 1ps
`default_nettype none

module pud_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_in_byte,
    input  wire logic           i_is_last,
    input  wire logic [15:0]    i_max_out_bytes,
    output pud_pkg::t_op        o_op,
    output logic                o_push
);
    import pud_pkg::*;

    logic [1:0]  r_pc;
    logic [7:0]  r_pb1;
    logic [15:0] r_emitted;
    logic [1:0]  n_pc;
    logic [7:0]  n_pb1;
    logic [15:0] n_emitted;

    logic [4:0]  h;
    logic [4:0]  hi;
    logic        is_pct;
    logic [7:0]  fresh_val;
    logic [7:0]  cand [4];
    logic [2:0]  ncand;
    logic [1:0]  ncap;
    logic [15:0] room;
    logic [1:0]  nbytes;
    logic [1:0]  pc_mid;

    // classify the incoming byte
    assign h         = hex_decode(i_in_byte);
    assign hi        = hex_decode(r_pb1);
    assign is_pct    = (i_in_byte == PCT_CHAR);
    assign fresh_val = (i_in_byte == PLUS_CHAR) ? SPACE_CHAR : i_in_byte;

    // candidate bytes in emit order, then the flush on the last byte
    always_comb begin
        ncand  = 3'd0;
        pc_mid = is_pct ? 2'd1 : 2'd0;
        n_pb1  = r_pb1;
        for (int k = 0; k < 4; k++) begin
            cand[k] = 8'h00;
        end
        case (r_pc)
            2'd1: begin
                if (h[4]) begin
                    pc_mid = 2'd2;
                    n_pb1  = i_in_byte;
                end else begin
                    cand[0] = PCT_CHAR;
                    ncand   = 3'd1;
                    if (!is_pct) begin
                        cand[1] = fresh_val;
                        ncand   = 3'd2;
                    end
                end
            end
            2'd2: begin
                if (h[4] && hi[4]) begin
                    cand[0] = {hi[3:0], h[3:0]};
                    ncand   = 3'd1;
                    pc_mid  = 2'd0;
                end else begin
                    cand[0] = PCT_CHAR;
                    cand[1] = r_pb1;
                    ncand   = 3'd2;
                    if (!is_pct) begin
                        cand[2] = fresh_val;
                        ncand   = 3'd3;
                    end
                end
            end
            default: begin
                if (!is_pct) begin
                    cand[0] = fresh_val;
                    ncand   = 3'd1;
                end
            end
        endcase
        if (i_is_last && pc_mid != 2'd0 && ncand < 3'd4) begin
            cand[ncand[1:0]] = PCT_CHAR;
            ncand            = ncand + 3'd1;
        end
        if (i_is_last && pc_mid == 2'd2 && ncand < 3'd4) begin
            cand[ncand[1:0]] = n_pb1;
            ncand            = ncand + 3'd1;
        end
    end

    // apply the per-transaction cap and the output byte limit
    always_comb begin
        ncap   = (ncand > 3'(MAX_RESULTS)) ? 2'(MAX_RESULTS) : ncand[1:0];
        room   = (r_emitted >= i_max_out_bytes) ? 16'd0 : (i_max_out_bytes - r_emitted);
        nbytes = (room < 16'(ncap)) ? room[1:0] : ncap;
    end

    // next state, cleared at the end of a string
    always_comb begin
        if (i_is_last) begin
            n_pc      = 2'd0;
            n_emitted = 16'd0;
        end else begin
            n_pc      = pc_mid;
            n_emitted = r_emitted + 16'(nbytes);
        end
    end

    // op handed to the queue
    always_comb begin
        o_op.bytes[0] = cand[0];
        o_op.bytes[1] = cand[1];
        o_op.bytes[2] = cand[2];
        o_op.nbytes   = nbytes;
        o_op.last     = i_is_last;
        o_op.base     = r_emitted;
        o_push        = i_accept && (nbytes != 2'd0 || i_is_last);
    end

    // escape and count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= 2'd0;
            r_pb1     <= 8'h00;
            r_emitted <= 16'd0;
        end else if (i_accept) begin
            r_pc      <= n_pc;
            r_pb1     <= i_is_last ? 8'h00 : n_pb1;
            r_emitted <= n_emitted;
        end
    end

endmodule

`default_nettype wire

// File: design/pud_queue.sv
// short op queue between the front end and the result sequencer
// depends on pud_pkg
`timescale 1ns / 1ps
`default_nettype none

module pud_queue #(
    parameter int DEPTH = pud_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pud_pkg::t_op   i_op,
    input  wire logic           i_pop,
    output pud_pkg::t_op        o_head,
    output pud_pkg::t_q_stat    o_stat
);
    import pud_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.empty = (r_count == CNT_W'(0));
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/pud_back.sv
// result sequencer: walks the head op one result per cycle into the output register
// while the output is not stalled and an op waits; depends on pud_pkg
`timescale 1ns / 1ps
`default_nettype none

module pud_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pud_pkg::t_op      i_head,
    input  wire pud_pkg::t_q_stat  i_stat,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [7:0]             o_out_byte,
    output logic                   o_has_byte,
    output logic                   o_end_of_string,
    output logic [15:0]            o_decoded_count
);
    import pud_pkg::*;

    logic [1:0]  r_k;
    logic        load;
    logic        take;
    logic [1:0]  last_idx;
    logic        marker;
    logic [7:0]  res_byte;
    logic        res_eos;
    logic [15:0] res_count;

    // result k of the head op
    always_comb begin
        marker    = (i_head.nbytes == 2'd0);
        last_idx  = marker ? 2'd0 : (i_head.nbytes - 2'd1);
        res_byte  = marker ? 8'h00 : i_head.bytes[r_k];
        res_eos   = i_head.last && (r_k == last_idx);
        res_count = marker ? i_head.base : (i_head.base + 16'(r_k) + 16'd1);
    end

    // output register refills when empty or when its transaction completes
    assign load  = !o_out_valid || !i_out_stall;
    assign take  = load && !i_stat.empty;
    assign o_pop = take && (r_k == last_idx);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
            r_k         <= 2'd0;
        end else begin
            if (load) begin
                o_out_valid <= !i_stat.empty;
            end
            if (o_pop) begin
                r_k <= 2'd0;
            end else if (take) begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            o_out_byte      <= res_byte;
            o_has_byte      <= !marker;
            o_end_of_string <= res_eos;
            o_decoded_count <= res_count;
        end
    end

endmodule

`default_nettype wire

// File: design/percent_url_decoder_core.sv
// top level of the percent url decoder: limit register, front end, op queue, sequencer
// depends on pud_pkg, pud_front, pud_queue, pud_back
`timescale 1ns / 1ps
`default_nettype none

// Streaming URL decoder: one encoded byte per transaction in, decoded bytes out,
// with "%hh" turned into one byte and "+" into a space. An input byte is taken
// every cycle while the op queue (QUEUE_DEPTH entries) has room; each input
// yields zero to three results and the sequencer drives one result per cycle
// while the output is not stalled, so the sustained rate is one input per cycle
// while inputs average at most one result. The last byte of a string always
// yields at least one result, flagged end_of_string, whose decoded_count is the
// number of decoded bytes emitted for the string. max_out_bytes is to be
// written only while the block is idle; the block itself does not enforce this.
module percent_url_decoder_core #(
    parameter int QUEUE_DEPTH = pud_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_has_byte,
    output logic             o_end_of_string,
    output logic [15:0]      o_decoded_count,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data
);
    import pud_pkg::*;

    logic [15:0] r_max_out_bytes;
    logic        in_accept;
    logic        push;
    logic        pop;
    t_op         op;
    t_op         head;
    t_q_stat     stat;

    // output byte limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out_bytes <= MAX_OUT_RESET;
        end else if (i_cfg_we) begin
            r_max_out_bytes <= i_cfg_data;
        end
    end

    assign o_in_stall = stat.full;
    assign in_accept  = i_in_valid && !o_in_stall;

    pud_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_in_byte       (i_in_byte),
        .i_is_last       (i_is_last),
        .i_max_out_bytes (r_max_out_bytes),
        .o_op            (op),
        .o_push          (push)
    );

    pud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (op),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    pud_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_stat          (stat),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_has_byte      (o_has_byte),
        .o_end_of_string (o_end_of_string),
        .o_decoded_count (o_decoded_count)
    );

    // queue status is never both full and empty
    a_stat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.full && stat.empty))
        else $error("queue reports full and empty together");

    // only ops that produce a result enter the queue
    a_push_useful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (op.nbytes != 2'd0 || op.last))
        else $error("queued op carries no result");

    // a result without a byte is always the end-of-string marker
    a_marker_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_byte) |-> o_end_of_string)
        else $error("byte-less result without end of string");

    // a byte result always counts at least one emitted byte
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_has_byte) |-> (o_decoded_count != 16'd0))
        else $error("byte result with zero count");

endmodule

`default_nettype wire

// File: dv/pud_checker.sv
`timescale 1ns / 1ps
// checker for the percent url decoder: watches the byte, result and limit channels,
// predicts the decoded results and compares them with the block's output
// depends on pud_pkg for the character constants, the limit reset value and MAX_RESULTS
module pud_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_is_last,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [7:0]  i_out_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_string,
    input  wire logic [15:0] i_decoded_count,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_waiting
);
    import pud_pkg::*;

    localparam int NO_DIGIT = 16;

    typedef struct {
        logic [7:0]  data;
        logic        has_byte;
        logic        eos;
        logic [15:0] count;
    } t_decoded;

    t_decoded    decoded_q[$];   // expected results, oldest first
    t_decoded    step_res[$];    // results of the transaction being predicted
    t_decoded    oldest;
    logic [7:0]  held_digit;
    logic [1:0]  held_count;     // 0 nothing held, 1 percent held, 2 percent and digit held
    logic [15:0] emitted;
    logic [15:0] out_limit;
    int          last_emit;
    int          fails = 0;

    // value of a hex digit in either case, NO_DIGIT for anything else
    function automatic int digit_value(input logic [7:0] c);
        int v;
        v = NO_DIGIT;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h61 + 10;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h41 + 10;
        end
        return v;
    endfunction

    // one decoded byte, dropped once the limit or the per-transaction result cap is hit
    task automatic emit_byte(input logic [7:0] b);
        t_decoded r;
        if (emitted >= out_limit || step_res.size() >= MAX_RESULTS) return;
        emitted    = emitted + 16'd1;
        r.data     = b;
        r.has_byte = 1'b1;
        r.eos      = 1'b0;
        r.count    = emitted;
        step_res.push_back(r);
        last_emit = step_res.size() - 1;
    endtask

    // byte looked at with nothing held
    task automatic scan_fresh(input logic [7:0] b);
        if (b == PCT_CHAR) begin
            held_count = 2'd1;
        end else if (b == PLUS_CHAR) begin
            emit_byte(SPACE_CHAR);
        end else begin
            emit_byte(b);
        end
    endtask

    // expected results of one input transaction
    task automatic predict_decode(input logic [7:0] b, input logic is_last);
        int       d;
        int       hi;
        t_decoded r;
        step_res.delete();
        last_emit = -1;
        d = digit_value(b);
        case (held_count)
            2'd1: begin
                if (d != NO_DIGIT) begin
                    held_digit = b;
                    held_count = 2'd2;
                end else begin
                    held_count = 2'd0;
                    emit_byte(PCT_CHAR);
                    scan_fresh(b);
                end
            end
            2'd2: begin
                hi = digit_value(held_digit);
                held_count = 2'd0;
                if (d != NO_DIGIT && hi != NO_DIGIT) begin
                    emit_byte(8'((hi << 4) | d));
                end else begin
                    // broken escape: percent and held digit go out as literals
                    emit_byte(PCT_CHAR);
                    emit_byte(held_digit);
                    scan_fresh(b);
                end
            end
            default: begin
                held_count = 2'd0;
                scan_fresh(b);
            end
        endcase
        // end of string: flush held bytes, mark the final result
        if (is_last) begin
            if (held_count >= 2'd1) emit_byte(PCT_CHAR);
            if (held_count == 2'd2) emit_byte(held_digit);
            if (last_emit >= 0 && last_emit == step_res.size() - 1) begin
                step_res[last_emit].eos = 1'b1;
            end else if (step_res.size() < MAX_RESULTS) begin
                r.data     = 8'h00;
                r.has_byte = 1'b0;
                r.eos      = 1'b1;
                r.count    = emitted;
                step_res.push_back(r);
            end
            held_digit = 8'h00;
            held_count = 2'd0;
            emitted    = 16'd0;
        end
        foreach (step_res[i]) decoded_q.push_back(step_res[i]);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // predict on accepted input, compare on accepted output
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_digit = 8'h00;
            held_count = 2'd0;
            emitted    = 16'd0;
            out_limit  = MAX_OUT_RESET;
            decoded_q.delete();
        end else begin
            if (i_cfg_we) out_limit = i_cfg_data;
            if (i_in_valid && !i_in_stall) predict_decode(i_in_byte, i_is_last);
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    fails++;
                    $display("%0t: result with nothing expected, actual byte %0h has %b eos %b count %0d",
                             $time, i_out_byte, i_has_byte, i_end_of_string, i_decoded_count);
                end else begin
                    oldest = decoded_q.pop_front();
                    check_field("out_byte", 16'(oldest.data), 16'(i_out_byte));
                    check_field("has_byte", 16'(oldest.has_byte), 16'(i_has_byte));
                    check_field("end_of_string", 16'(oldest.eos), 16'(i_end_of_string));
                    check_field("decoded_count", oldest.count, i_decoded_count);
                end
            end
        end
        o_fail_count <= fails;
        o_waiting    <= decoded_q.size();
    end

endmodule

// File: dv/tb_percent_url_decoder_core.sv
`timescale 1ns / 1ps
// testbench top for percent_url_decoder_core: clock, reset, byte strings, limit writes
// and the verdict; depends on pud_pkg, percent_url_decoder_core and pud_checker
module tb_percent_url_decoder_core;
    import pud_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 260;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte   = 8'h00;
    logic        in_last   = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        end_of_string;
    logic [15:0] decoded_count;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_data  = 16'h0000;

    int          fail_count;
    int          waiting;
    int          cycle_count    = 0;
    int          items_sent     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_id        = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;
    logic [7:0]  str_bytes[$];

    always #6 clk = ~clk;

    percent_url_decoder_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_in_byte       (in_byte),
        .i_is_last       (in_last),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_out_byte      (out_byte),
        .o_has_byte      (has_byte),
        .o_end_of_string (end_of_string),
        .o_decoded_count (decoded_count),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data)
    );

    pud_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_byte       (in_byte),
        .i_is_last       (in_last),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_byte      (out_byte),
        .i_has_byte      (has_byte),
        .i_end_of_string (end_of_string),
        .i_decoded_count (decoded_count),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_waiting       (waiting)
    );

    // receiver: random stall, or a long hold-off each time hold_id moves
    always @(posedge clk) begin
        if (hold_seen != hold_id) begin
            hold_seen = hold_id;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL percent_url_decoder_core");
            $finish;
        end
    end

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(21);
        if (v < 10) return 8'(8'h30 + v);
        if (v < 16) return 8'(8'h61 + v - 10);
        return 8'(8'h41 + v - 16);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]}) b = b ^ 8'h80;
        return b;
    endfunction

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // one byte transaction, with a random gap in front of it
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= is_last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_string();
        foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    // random string: raw bytes, plus signs, well-formed escapes, broken ones and lone percents
    task automatic build_string();
        int len;
        int pick;
        str_bytes.delete();
        len = $urandom_range(1, 24);
        while (str_bytes.size() < len) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                str_bytes.push_back(8'($urandom_range(255)));
            end else if (pick < 45) begin
                str_bytes.push_back(PLUS_CHAR);
            end else if (pick < 75) begin
                str_bytes.push_back(PCT_CHAR);
                str_bytes.push_back(hex_char());
                str_bytes.push_back(hex_char());
            end else if (pick < 85) begin
                str_bytes.push_back(PCT_CHAR);
                str_bytes.push_back(non_hex_char());
            end else if (pick < 95) begin
                str_bytes.push_back(PCT_CHAR);
                str_bytes.push_back(hex_char());
                str_bytes.push_back(non_hex_char());
            end else begin
                str_bytes.push_back(PCT_CHAR);
            end
        end
    endtask

    // no input in flight and every expected result seen, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        int          phase_start;
        logic [15:0] lim;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // escapes in both cases, plus, broken escapes, top byte, held percent at the end
        str_bytes = {PCT_CHAR, 8'h34, 8'h31, PLUS_CHAR, PCT_CHAR, 8'h66, 8'h46,
                     PCT_CHAR, 8'h67, 8'hFF, PCT_CHAR};
        send_string();
        // broken escape on the last byte: three results
        str_bytes = {PCT_CHAR, 8'h35, 8'h78};
        send_string();
        // broken escape followed by a new percent on the last byte, flushed: three results
        str_bytes = {PCT_CHAR, 8'h35, PCT_CHAR};
        send_string();
        // percent and digit held at the end
        str_bytes = {PCT_CHAR, 8'h61};
        send_string();
        // zero limit: only the final count comes out
        write_limit(16'h0000);
        str_bytes = {8'h00, PCT_CHAR, 8'h34, 8'h31};
        send_string();
        // limit reached mid-string
        write_limit(16'd2);
        str_bytes = {8'h61, 8'h62, 8'h63, 8'h64};
        send_string();
        write_limit(16'hFFFF);

        // receiver holds off while bytes keep coming, so the block backs up
        hold_id <= hold_id + 1;
        repeat (2) begin
            build_string();
            send_string();
        end

        // random strings under each idling mix, with limit changes between strings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_idling(0, 0);
                1: set_idling(75, 0);
                2: set_idling(0, 75);
                default: set_idling(19, 19);
            endcase
            phase_start = items_sent;
            while (items_sent < phase_start + RANDOM_ITEMS / 4) begin
                if ($urandom_range(99) < 30) begin
                    case ($urandom_range(7))
                        0: lim = 16'h0000;
                        1: lim = 16'hFFFF;
                        2: lim = MAX_OUT_RESET;
                        3: lim = 16'($urandom_range(1, 3));
                        default: lim = 16'($urandom_range(1, 30));
                    endcase
                    write_limit(lim);
                end
                build_string();
                send_string();
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("PASS percent_url_decoder_core");
        end else begin
            $display("FAIL percent_url_decoder_core");
        end
        $finish;
    end

endmodule
